// ===== rtl/complex_list_reducer_unit_assert.svh =====
`ifndef COMPLEX_LIST_REDUCER_UNIT_ASSERT_SVH
`define COMPLEX_LIST_REDUCER_UNIT_ASSERT_SVH

// consequent in the cycle after the antecedent
`define CLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("complex_list_reducer_unit: assertion violated");

// consequent in the same cycle as the antecedent
`define CLR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("complex_list_reducer_unit: assertion violated");

`endif

// ===== rtl/clr_pkg.sv =====
package clr_pkg;

   localparam int DATA_W = 32;
   localparam int PROD_W = 64;
   localparam int SUM_W  = 66;
   localparam int MAG_W  = 64;
   localparam int MODE_W = 2;

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [MODE_W-1:0] {
      MODE_SUM  = 2'd0,
      MODE_DIFF = 2'd1,
      MODE_PROD = 2'd2,
      MODE_QUOT = 2'd3
   } mode_type;

   typedef struct packed {
      logic done;
      logic sat;
   } div_stat_type;

endpackage

// ===== rtl/clr_divider.sv =====
module clr_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               neg,
   input  logic [clr_pkg::MAG_W-1:0]          mag,
   input  logic [clr_pkg::MAG_W-1:0]          den,
   output logic signed [clr_pkg::DATA_W-1:0]  quo,
   output clr_pkg::div_stat_type              stat
);
   import clr_pkg::*;

   localparam int DVD_W = MAG_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic                run_ff, run_in;
   logic                fin_ff, fin_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [MAG_W-1:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]    den_ff, den_in;
   logic [DATA_W:0]     quo_ff, quo_in;
   logic                ovf_ff, ovf_in;
   logic                neg_ff, neg_in;

   logic [MAG_W:0]      trial;
   logic [MAG_W:0]      diff;
   logic                ge;
   logic                big;
   logic [DATA_W-1:0]   low;
   logic                sat;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      run_in = run_ff;
      fin_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      neg_in = neg_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = {mag, {FRAC_BITS{1'b0}}};
         rem_in = '0;
         den_in = den;
         quo_in = '0;
         ovf_in = 1'b0;
         neg_in = neg;
      end else if (run_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
         quo_in = {quo_ff[DATA_W-1:0], ge};
         ovf_in = ovf_ff | quo_ff[DATA_W];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   // clamp the magnitude to the signed 32-bit range
   assign big = ovf_ff | quo_ff[DATA_W];
   assign low = quo_ff[DATA_W-1:0];
   assign sat = neg_ff ? (big || (low > SAT_MIN)) : (big || low[DATA_W-1]);

   always_comb begin
      if (sat) begin
         quo = neg_ff ? SAT_MIN : SAT_MAX;
      end else if (neg_ff) begin
         quo = -$signed(low);
      end else begin
         quo = $signed(low);
      end
   end

   assign stat.done = fin_ff;
   assign stat.sat  = sat;

endmodule

// ===== rtl/complex_list_reducer_unit.sv =====
// Reduces a sequence of signed fixed-point complex values (FRAC_BITS fraction bits in 32)
// to one result, sent on the item marked last: sum, difference from the first element,
// product, or the first element divided by the product of the rest, as csr_wr_data
// selects. A one-element sequence returns that element. One 32x32 multiplier and one
// bit-serial divider are shared under a sequencer, and req_stall is high while an item
// is in work. A product item (and a quotient item after the second element) runs its
// four multiplies. The last item hands the result to the output register, and in
// quotient mode first forms the divisor and numerator products and, for a nonzero
// divisor, runs two divisions, one quotient bit a cycle. The unit takes the next item
// while a result waits on rsp_stall; the next result then waits until the output
// register is free.
module complex_list_reducer_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [clr_pkg::DATA_W-1:0] req_value_re,
   input  logic signed [clr_pkg::DATA_W-1:0] req_value_im,
   input  logic                              req_last_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [clr_pkg::DATA_W-1:0] rsp_result_re,
   output logic signed [clr_pkg::DATA_W-1:0] rsp_result_im,
   output logic                              rsp_divide_by_zero,
   output logic                              rsp_saturated,
   input  logic                              csr_wr_en,
   input  logic [clr_pkg::MODE_W-1:0]        csr_wr_data
);
   import clr_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_STEP,
      S_CM0, S_CM1, S_CM2, S_CM3, S_CM4, S_CM5,
      S_FIN,
      S_QM0, S_QM1, S_QM2, S_QM3, S_QM4, S_QM5, S_QM6, S_QM7,
      S_DRE, S_DIM, S_PUSH
   } state_type;

   state_type                  state_ff, state_in;
   mode_type                   op_mode_ff, op_mode_in;
   mode_type                   mode_ff, mode_in;
   logic                       at_start_ff, at_start_in;
   logic                       second_pending_ff, second_pending_in;
   logic                       sat_seen_ff, sat_seen_in;
   logic signed [DATA_W-1:0]   acc_re_ff, acc_re_in;
   logic signed [DATA_W-1:0]   acc_im_ff, acc_im_in;
   logic signed [DATA_W-1:0]   numer_re_ff, numer_re_in;
   logic signed [DATA_W-1:0]   numer_im_ff, numer_im_in;
   logic signed [DATA_W-1:0]   in_re_ff, in_re_in;
   logic signed [DATA_W-1:0]   in_im_ff, in_im_in;
   logic                       in_last_ff, in_last_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SUM_W-1:0]    numre_ff, numre_in;
   logic [MAG_W-1:0]           den_ff, den_in;
   logic signed [DATA_W-1:0]   tmp_re_ff, tmp_re_in;
   logic                       tmp_sat_ff, tmp_sat_in;
   logic signed [DATA_W-1:0]   res_re_ff, res_re_in;
   logic signed [DATA_W-1:0]   res_im_ff, res_im_in;
   logic                       res_dz_ff, res_dz_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_re_ff, rsp_re_in;
   logic signed [DATA_W-1:0]   rsp_im_ff, rsp_im_in;
   logic                       rsp_dz_ff, rsp_dz_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic signed [DATA_W-1:0]   mul_a;
   logic signed [DATA_W-1:0]   mul_b;
   logic [DATA_W:0]            add_re;
   logic [DATA_W:0]            add_im;
   logic [DATA_W:0]            fix_sum;
   logic signed [SUM_W-1:0]    div_src;
   logic signed [SUM_W-1:0]    div_abs;
   logic                       div_neg;
   logic                       div_start;
   logic signed [DATA_W-1:0]   div_quo;
   div_stat_type               div_stat;

   // {clamped, value}
   function automatic logic [DATA_W:0] sat_add(input logic signed [DATA_W-1:0] a,
                                               input logic signed [DATA_W-1:0] b,
                                               input logic                     sub);
      logic [DATA_W:0] s;
      s = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b})
              : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
      if (s[DATA_W] != s[DATA_W-1]) begin
         return {1'b1, (s[DATA_W] ? SAT_MIN : SAT_MAX)};
      end
      return {1'b0, s[DATA_W-1:0]};
   endfunction

   // floor shift by FRAC_BITS, then clamp; {clamped, value}
   function automatic logic [DATA_W:0] fix_q(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] sh;
      logic                    fit;
      sh  = v >>> FRAC_BITS;
      fit = (&sh[SUM_W-1:DATA_W-1]) | ~(|sh[SUM_W-1:DATA_W-1]);
      if (!fit) begin
         return {1'b1, (sh[SUM_W-1] ? SAT_MIN : SAT_MAX)};
      end
      return {1'b0, sh[DATA_W-1:0]};
   endfunction

   assign add_re  = sat_add(acc_re_ff, in_re_ff, mode_ff == MODE_DIFF);
   assign add_im  = sat_add(acc_im_ff, in_im_ff, mode_ff == MODE_DIFF);
   assign fix_sum = fix_q(sum_ff);

   always_comb begin
      case (state_ff)
         S_CM0: begin
            mul_a = acc_re_ff;
            mul_b = in_re_ff;
         end
         S_CM1: begin
            mul_a = acc_im_ff;
            mul_b = in_im_ff;
         end
         S_CM2: begin
            mul_a = acc_im_ff;
            mul_b = in_re_ff;
         end
         S_CM3: begin
            mul_a = acc_re_ff;
            mul_b = in_im_ff;
         end
         S_QM0: begin
            mul_a = acc_re_ff;
            mul_b = acc_re_ff;
         end
         S_QM1: begin
            mul_a = acc_im_ff;
            mul_b = acc_im_ff;
         end
         S_QM2: begin
            mul_a = numer_re_ff;
            mul_b = acc_re_ff;
         end
         S_QM3: begin
            mul_a = numer_im_ff;
            mul_b = acc_im_ff;
         end
         S_QM4: begin
            mul_a = numer_im_ff;
            mul_b = acc_re_ff;
         end
         S_QM5: begin
            mul_a = numer_re_ff;
            mul_b = acc_im_ff;
         end
         default: begin
            mul_a = acc_re_ff;
            mul_b = in_re_ff;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign div_src   = (state_ff == S_QM7) ? numre_ff : sum_ff;
   assign div_neg   = div_src[SUM_W-1];
   assign div_abs   = div_neg ? -div_src : div_src;
   assign div_start = ((state_ff == S_QM7) && (den_ff != '0)) ||
                      ((state_ff == S_DRE) && div_stat.done);

   clr_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .neg   (div_neg),
      .mag   (div_abs[MAG_W-1:0]),
      .den   (den_ff),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   always_comb begin
      state_in          = state_ff;
      op_mode_in        = op_mode_ff;
      mode_in           = mode_ff;
      at_start_in       = at_start_ff;
      second_pending_in = second_pending_ff;
      sat_seen_in       = sat_seen_ff;
      acc_re_in         = acc_re_ff;
      acc_im_in         = acc_im_ff;
      numer_re_in       = numer_re_ff;
      numer_im_in       = numer_im_ff;
      in_re_in          = in_re_ff;
      in_im_in          = in_im_ff;
      in_last_in        = in_last_ff;
      sum_in            = sum_ff;
      numre_in          = numre_ff;
      den_in            = den_ff;
      tmp_re_in         = tmp_re_ff;
      tmp_sat_in        = tmp_sat_ff;
      res_re_in         = res_re_ff;
      res_im_in         = res_im_ff;
      res_dz_in         = res_dz_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_re_in         = rsp_re_ff;
      rsp_im_in         = rsp_im_ff;
      rsp_dz_in         = rsp_dz_ff;
      rsp_sat_in        = rsp_sat_ff;

      if (csr_wr_en) begin
         op_mode_in = mode_type'(csr_wr_data);
      end

      // drop the output once transferred
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               in_re_in   = req_value_re;
               in_im_in   = req_value_im;
               in_last_in = req_last_item;
               mode_in    = op_mode_ff;
               state_in   = S_STEP;
            end
         end
         S_STEP: begin
            if (at_start_ff) begin
               if (in_last_ff) begin
                  res_re_in = in_re_ff;
                  res_im_in = in_im_ff;
                  res_dz_in = 1'b0;
                  state_in  = S_PUSH;
               end else begin
                  acc_re_in         = in_re_ff;
                  acc_im_in         = in_im_ff;
                  numer_re_in       = in_re_ff;
                  numer_im_in       = in_im_ff;
                  second_pending_in = (mode_ff == MODE_QUOT);
                  sat_seen_in       = 1'b0;
                  at_start_in       = 1'b0;
                  state_in          = S_IDLE;
               end
            end else begin
               case (mode_ff)
                  MODE_SUM, MODE_DIFF: begin
                     acc_re_in   = add_re[DATA_W-1:0];
                     acc_im_in   = add_im[DATA_W-1:0];
                     sat_seen_in = sat_seen_ff | add_re[DATA_W] | add_im[DATA_W];
                     state_in    = in_last_ff ? S_FIN : S_IDLE;
                  end
                  MODE_PROD: begin
                     state_in = S_CM0;
                  end
                  MODE_QUOT: begin
                     if (second_pending_ff) begin
                        acc_re_in         = in_re_ff;
                        acc_im_in         = in_im_ff;
                        second_pending_in = 1'b0;
                        state_in          = in_last_ff ? S_FIN : S_IDLE;
                     end else begin
                        state_in = S_CM0;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CM0: begin
            state_in = S_CM1;
         end
         S_CM1: begin
            sum_in   = SUM_W'(prod_ff);
            state_in = S_CM2;
         end
         S_CM2: begin
            sum_in   = sum_ff - SUM_W'(prod_ff);
            state_in = S_CM3;
         end
         S_CM3: begin
            tmp_re_in  = fix_sum[DATA_W-1:0];
            tmp_sat_in = fix_sum[DATA_W];
            sum_in     = SUM_W'(prod_ff);
            state_in   = S_CM4;
         end
         S_CM4: begin
            sum_in   = sum_ff + SUM_W'(prod_ff);
            state_in = S_CM5;
         end
         S_CM5: begin
            acc_re_in   = tmp_re_ff;
            acc_im_in   = fix_sum[DATA_W-1:0];
            sat_seen_in = sat_seen_ff | tmp_sat_ff | fix_sum[DATA_W];
            state_in    = in_last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (mode_ff == MODE_QUOT) begin
               state_in = S_QM0;
            end else begin
               res_re_in = acc_re_ff;
               res_im_in = acc_im_ff;
               res_dz_in = 1'b0;
               state_in  = S_PUSH;
            end
         end
         S_QM0: begin
            state_in = S_QM1;
         end
         S_QM1: begin
            sum_in   = SUM_W'(prod_ff);
            state_in = S_QM2;
         end
         S_QM2: begin
            sum_in   = sum_ff + SUM_W'(prod_ff);
            state_in = S_QM3;
         end
         S_QM3: begin
            den_in   = sum_ff[MAG_W-1:0];
            sum_in   = SUM_W'(prod_ff);
            state_in = S_QM4;
         end
         S_QM4: begin
            sum_in   = sum_ff + SUM_W'(prod_ff);
            state_in = S_QM5;
         end
         S_QM5: begin
            numre_in = sum_ff;
            sum_in   = SUM_W'(prod_ff);
            state_in = S_QM6;
         end
         S_QM6: begin
            sum_in   = sum_ff - SUM_W'(prod_ff);
            state_in = S_QM7;
         end
         S_QM7: begin
            if (den_ff == '0) begin
               res_re_in = '0;
               res_im_in = '0;
               res_dz_in = 1'b1;
               state_in  = S_PUSH;
            end else begin
               state_in = S_DRE;
            end
         end
         S_DRE: begin
            if (div_stat.done) begin
               res_re_in   = div_quo;
               sat_seen_in = sat_seen_ff | div_stat.sat;
               state_in    = S_DIM;
            end
         end
         S_DIM: begin
            if (div_stat.done) begin
               res_im_in   = div_quo;
               res_dz_in   = 1'b0;
               sat_seen_in = sat_seen_ff | div_stat.sat;
               state_in    = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_re_in         = res_re_ff;
               rsp_im_in         = res_im_ff;
               rsp_dz_in         = res_dz_ff;
               rsp_sat_in        = sat_seen_ff;
               at_start_in       = 1'b1;
               second_pending_in = 1'b0;
               sat_seen_in       = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         op_mode_ff        <= MODE_SUM;
         at_start_ff       <= 1'b1;
         second_pending_ff <= 1'b0;
         sat_seen_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         op_mode_ff        <= op_mode_in;
         at_start_ff       <= at_start_in;
         second_pending_ff <= second_pending_in;
         sat_seen_ff       <= sat_seen_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      acc_re_ff   <= acc_re_in;
      acc_im_ff   <= acc_im_in;
      numer_re_ff <= numer_re_in;
      numer_im_ff <= numer_im_in;
      in_re_ff    <= in_re_in;
      in_im_ff    <= in_im_in;
      in_last_ff  <= in_last_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      numre_ff    <= numre_in;
      den_ff      <= den_in;
      tmp_re_ff   <= tmp_re_in;
      tmp_sat_ff  <= tmp_sat_in;
      res_re_ff   <= res_re_in;
      res_im_ff   <= res_im_in;
      res_dz_ff   <= res_dz_in;
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
      rsp_dz_ff   <= rsp_dz_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_re      = rsp_re_ff;
   assign rsp_result_im      = rsp_im_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule

// ===== rtl/clr_checker.sv =====
`include "complex_list_reducer_unit_assert.svh"

module clr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_re,
   input logic [31:0] rsp_result_im,
   input logic        rsp_divide_by_zero
);

   `CLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_re) && $stable(rsp_result_im))
   `CLR_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall)
   `CLR_ASSERT_SAME(a_dz_zero_result, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_result_re == 32'd0 && rsp_result_im == 32'd0)
   `CLR_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind complex_list_reducer_unit clr_checker u_clr_checker (.*);
